@@ sv/mhns_pkg.sv @@
// Package for the held-note stack with MIDI thru.
// Holds the shared message codes, the stack command and status types, and the pitch-class helper.
// No dependencies.
package mhns_pkg;

   // Incoming message kinds. Any other code is ignored.
   localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
   localparam logic [1:0] KIND_NOTE_ON  = 2'd1;

   // Status byte bases for thru messages.
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

   // Velocity after reset.
   localparam logic [6:0] VELOCITY_RESET = 7'd100;

   // Root value reported when no note is held.
   localparam logic signed [7:0] ROOT_EMPTY = -8'sd1;

   // Pitch classes per octave and the reciprocal used to divide a note number by it.
   localparam int unsigned PITCH_CLASSES   = 12;
   localparam int unsigned RECIP_MULT      = 43;
   localparam int unsigned RECIP_SHIFT     = 9;

   // Operation handed to the stack controller for one transaction.
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2
   } stack_op_type;

   typedef struct packed {
      stack_op_type op;
      logic [6:0]   note;
   } stack_cmd_type;

   // Report from the stack controller when a transaction has finished.
   typedef struct packed {
      logic              done;
      logic signed [7:0] root;
      logic [4:0]        held_count;
   } stack_status_type;

   // Note number modulo twelve. The quotient comes from a multiply by a
   // reciprocal, which is exact over the whole 7-bit note range.
   function automatic logic [3:0] pitch_class(input logic [6:0] note);
      logic [12:0] prod;
      logic [3:0]  quot;
      logic [6:0]  rem;
      prod = 13'(note) * 13'(RECIP_MULT);
      quot = 4'(prod >> RECIP_SHIFT);
      rem  = note - 7'(quot * 7'(PITCH_CLASSES));
      return rem[3:0];
   endfunction

endpackage

@@ sv/mhns_stack_mem.sv @@
// Held-note stack storage: one write port and one read port, registered read data.
// Depends on nothing but its depth parameter.
module mhns_stack_mem #(
   parameter int unsigned DEPTH = 16,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [6:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [6:0]       rd_data
);

   logic [6:0] stack_mem_ff [DEPTH];
   logic [6:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port: the data of a read appears in the cycle after rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mhns_stack_ctrl.sv @@
// Stack controller: walks the memory to push or remove a note; every command reads the top.
// Depends on mhns_pkg and drives the ports of mhns_stack_mem.
module mhns_stack_ctrl
   import mhns_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  stack_cmd_type    cmd,
   output stack_status_type status,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output logic [6:0]       wr_data,
   output logic             rd_en,
   output logic [IDX_W-1:0] rd_addr,
   input  logic [6:0]       rd_data
);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_SCAN      = 5'b00010,
      S_FINISH    = 5'b00100,
      S_ROOT_RD   = 5'b01000,
      S_ROOT_WAIT = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic             pend_ff, pend_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] count_m1;
   logic             issue;

   assign count_m1 = count_ff - CNT_W'(1);
   assign issue    = (rd_ff < count_ff);

   // Sequencer: scan reads stream one entry a cycle; the data of each read is
   // handled in the following cycle, while the next read is already issued.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      pend_in  = 1'b0;
      found_in = found_ff;
      wr_en    = 1'b0;
      wr_addr  = wr_ff[IDX_W-1:0];
      wr_data  = rd_data;
      rd_en    = 1'b0;
      rd_addr  = rd_ff[IDX_W-1:0];
      status   = '{done: 1'b0, root: ROOT_EMPTY, held_count: 5'(count_ff)};

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               rd_in    = '0;
               wr_in    = '0;
               found_in = 1'b0;
               if (cmd.op == OP_NONE) begin
                  state_in = S_ROOT_RD;
               end else if (count_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Issue the next read while entries remain.
            if (issue) begin
               rd_en   = 1'b1;
               rd_in   = rd_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            // Handle the entry read in the previous cycle.
            if (pend_ff) begin
               if (cmd.op == OP_PUSH) begin
                  if (rd_data == cmd.note) begin
                     found_in = 1'b1;
                  end
               end else if (rd_data != cmd.note) begin
                  // Compact the stack: surviving notes move down in order.
                  wr_en = 1'b1;
                  wr_in = wr_ff + CNT_W'(1);
               end
            end
            if (!issue && !pend_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (cmd.op == OP_PUSH) begin
               if (!found_ff && (count_ff < CNT_W'(DEPTH))) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = cmd.note;
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               count_in = wr_ff;
            end
            state_in = S_ROOT_RD;
         end

         S_ROOT_RD: begin
            rd_en    = (count_ff != '0);
            rd_addr  = count_m1[IDX_W-1:0];
            state_in = S_ROOT_WAIT;
         end

         S_ROOT_WAIT: begin
            status.done = 1'b1;
            if (count_ff != '0) begin
               status.root = $signed({1'b0, rd_data});
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Scan pointers.
   always_ff @(posedge clock) begin
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      found_ff <= found_in;
   end

   // The stack never holds more notes than it has entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("stack count beyond depth");

   // Compaction writes never overtake the reads they depend on.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (wr_ff <= rd_ff))
      else $error("compaction write pointer ahead of read pointer");

   // Completion is reported for a single cycle.
   assert property (@(posedge clock) disable iff (reset) status.done |=> !status.done)
      else $error("done held for more than one cycle");

   // A finished transaction returns the controller to idle.
   assert property (@(posedge clock) disable iff (reset)
      status.done |=> (state_ff == S_IDLE))
      else $error("controller not idle after done");

endmodule

@@ sv/midi_held_note_stack_thru_unit.sv @@
// Top level of the held-note stack with MIDI thru: event decode, thru message, result register.
// Depends on mhns_pkg, mhns_stack_ctrl and mhns_stack_mem.
//
// One MIDI event is taken per transaction when start is high and busy is low. Exactly one
// result follows. It is shown for a single cycle with rsp_strobe, and the receiver cannot hold
// it off. The note stack lives in a memory with one read port, and a note on or note off
// walks every held entry one per cycle before the new top of stack is read back. A note
// event on an empty stack skips the walk, and an ignored event or a key select goes straight
// to the read of the top. busy falls in the strobe cycle, so the next event can be taken at
// the edge that ends it.
module midi_held_note_stack_thru_unit
   import mhns_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_message_kind,
   input  logic [3:0]        req_channel,
   input  logic [6:0]        req_note_number,
   input  logic [6:0]        req_velocity,
   input  logic              req_chord_type_held,
   input  logic              req_key_select_held,
   output logic              rsp_strobe,
   output logic              rsp_send_valid,
   output logic [7:0]        rsp_status_byte,
   output logic [6:0]        rsp_data_note,
   output logic [6:0]        rsp_data_velocity,
   output logic signed [7:0] rsp_current_root,
   output logic [4:0]        rsp_held_count,
   output logic [3:0]        rsp_key_class,
   output logic [6:0]        rsp_last_velocity,
   output logic [3:0]        rsp_out_channel
);

   localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic             accept;
   logic             busy_ff, busy_in;
   logic             cmd_valid_ff;
   stack_cmd_type    cmd_ff, cmd_in;
   stack_status_type status;
   logic [3:0]       channel_ff, channel_in;
   logic [3:0]       key_ff, key_in;
   logic [6:0]       vel_ff, vel_in;
   logic             send_ff, send_in;
   logic [7:0]       status_byte_ff, status_byte_in;
   logic [6:0]       dnote_ff, dnote_in;
   logic [6:0]       dvel_ff, dvel_in;
   logic             strobe_ff;
   logic             note_event;
   logic             note_on;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [6:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [6:0]       mem_rd_data;

   assign accept     = start && !busy_ff;
   assign note_event = (req_message_kind == KIND_NOTE_OFF) ||
                       (req_message_kind == KIND_NOTE_ON);
   assign note_on    = (req_message_kind == KIND_NOTE_ON) && (req_velocity != 7'd0);

   // Event decode: settings registers, stack command and thru message.
   always_comb begin
      channel_in     = channel_ff;
      key_in         = key_ff;
      vel_in         = vel_ff;
      cmd_in         = '{op: OP_NONE, note: req_note_number};
      send_in        = 1'b0;
      status_byte_in = 8'd0;
      dnote_in       = 7'd0;
      dvel_in        = 7'd0;
      if (note_event) begin
         channel_in = req_channel;
         if (note_on && req_key_select_held) begin
            key_in = pitch_class(req_note_number);
         end else begin
            if (note_on) begin
               vel_in    = req_velocity;
               cmd_in.op = OP_PUSH;
            end else begin
               cmd_in.op = OP_POP;
            end
            if (!req_chord_type_held) begin
               send_in  = 1'b1;
               dnote_in = req_note_number;
               if (note_on) begin
                  status_byte_in = STATUS_NOTE_ON | {4'd0, req_channel};
                  dvel_in        = req_velocity;
               end else begin
                  status_byte_in = STATUS_NOTE_OFF | {4'd0, req_channel};
               end
            end
         end
      end
   end

   // Transaction tracking.
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (status.done) begin
         busy_in = 1'b0;
      end
   end

   // Control and settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cmd_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
         channel_ff   <= 4'd0;
         key_ff       <= 4'd0;
         vel_ff       <= VELOCITY_RESET;
      end else begin
         busy_ff      <= busy_in;
         cmd_valid_ff <= accept;
         strobe_ff    <= status.done;
         if (accept) begin
            channel_ff <= channel_in;
            key_ff     <= key_in;
            vel_ff     <= vel_in;
         end
      end
   end

   // Per-transaction payload captured at acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff         <= cmd_in;
         send_ff        <= send_in;
         status_byte_ff <= status_byte_in;
         dnote_ff       <= dnote_in;
         dvel_ff        <= dvel_in;
      end
   end

   // Result register, loaded when the stack work has finished.
   always_ff @(posedge clock) begin
      if (status.done) begin
         rsp_send_valid    <= send_ff;
         rsp_status_byte   <= status_byte_ff;
         rsp_data_note     <= dnote_ff;
         rsp_data_velocity <= dvel_ff;
         rsp_current_root  <= status.root;
         rsp_held_count    <= status.held_count;
         rsp_key_class     <= key_ff;
         rsp_last_velocity <= vel_ff;
         rsp_out_channel   <= channel_ff;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   mhns_stack_ctrl #(
      .DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid_ff),
      .cmd       (cmd_ff),
      .status    (status),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_data   (mem_rd_data)
   );

   mhns_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // An accepted transaction keeps the block busy until its result.
   assert property (@(posedge clock) disable iff (reset) accept |=> busy_ff)
      else $error("busy not raised after acceptance");

   // A result is only produced for a transaction that was in flight.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy_ff))
      else $error("result without a transaction in flight");

   // The stack controller is only started while a transaction is open.
   assert property (@(posedge clock) disable iff (reset) cmd_valid_ff |-> busy_ff)
      else $error("stack command outside a transaction");

endmodule
